// File: rtl/rcpwm_pkg.sv
// Shared types and constants of the RC PWM pulse-width decoder.
`default_nettype none
package rcpwm_pkg;

	localparam int CH_BITS     = 2;
	localparam int TS_BITS     = 16;
	localparam int WIDTH_BITS  = 16;
	localparam int PERIOD_BITS = 17;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 17;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_JUMP   = 2'd1;

	localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 17'd10000;
	localparam logic [WIDTH_BITS-1:0]  JUMP_RESET   = 16'd500;
	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 16'd1500;
	localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX    = 16'hFFFF;

	typedef struct packed {
		logic [CH_BITS-1:0] channel;
		logic [TS_BITS-1:0] timestamp;
	} cap_t;

	typedef struct packed {
		logic [CH_BITS-1:0]    out_channel;
		logic [WIDTH_BITS-1:0] width;
		logic                  rejected;
	} pulse_t;

	typedef struct packed {
		logic [WIDTH_BITS-1:0] width;
		logic                  rejected;
	} calc_t;

endpackage
`default_nettype wire

// File: rtl/rc_pwm_pulse_width_decoder.sv
// A falling edge is registered in the second stage, then in the result register.
// Throughput: one capture event per cycle; the channel table is a registered memory
// read at acceptance and written back from the second stage, with a bypass.
// A stalled result register holds a falling edge in the second stage and the input.
// Reset (arst_n low, asynchronous) sets all channels to wait for a rising edge,
// last widths to 1500, counter_period to 10000 and max_jump to 500; no clearing pass.
`default_nettype none
module rc_pwm_pulse_width_decoder #(
	parameter int CHANNELS  = 4,
	parameter int TIME_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cap_valid,
	output logic                                     cap_ready,
	input  wire rcpwm_pkg::cap_t                     cap,
	output logic                                     pulse_valid,
	input  wire logic                                pulse_ready,
	output rcpwm_pkg::pulse_t                        pulse,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rcpwm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [rcpwm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import rcpwm_pkg::*;

	localparam int CH_REACH = 1 << CH_BITS;
	localparam int DEPTH    = (CHANNELS < CH_REACH) ? CHANNELS : CH_REACH;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW       = (TIME_BITS < TS_BITS) ? TIME_BITS : TS_BITS;
	localparam int WW       = RW + WIDTH_BITS;

	logic [PERIOD_BITS-1:0] period_q;
	logic [WIDTH_BITS-1:0]  jump_q;

	// Each entry holds the rise time above the last accepted width.
	logic [WW-1:0]    mem [DEPTH];
	logic [WW-1:0]    rd_q;
	logic [DEPTH-1:0] await_q;
	logic [DEPTH-1:0] vld_q;

	logic            valid_s1;
	logic            ok_s1;
	logic [AW-1:0]   ch_s1;
	logic [RW-1:0]   ts_s1;
	logic            byp_s1;
	logic [WW-1:0]   byp_word_s1;

	logic            cap_fire;
	logic            in_range;
	logic [WW-1:0]   word_s1;
	logic [RW-1:0]   cur_rise;
	logic [WIDTH_BITS-1:0] cur_last;
	logic            is_fall;
	logic            out_free;
	logic            s1_go;
	logic            wr_en;
	logic [WW-1:0]   wr_word;
	calc_t           calc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			jump_q   <= JUMP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PERIOD: period_q <= cfg_data;
				REG_JUMP:   jump_q   <= cfg_data[WIDTH_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign in_range = 32'(cap.channel) < CHANNELS;
	assign cap_fire = cap_valid && cap_ready;

	// A forwarded entry is always valid, since every write marks its entry valid.
	assign word_s1  = byp_s1 ? byp_word_s1 : rd_q;
	assign cur_rise = word_s1[WW-1:WIDTH_BITS];
	assign cur_last = vld_q[ch_s1] ? word_s1[WIDTH_BITS-1:0] : WIDTH_RESET;
	assign is_fall  = await_q[ch_s1];

	rcpwm_width_calc u_calc (
		.fall_time      (TS_BITS'(ts_s1)),
		.rise_time      (TS_BITS'(cur_rise)),
		.last_width     (cur_last),
		.counter_period (period_q),
		.max_jump       (jump_q),
		.result         (calc)
	);

	assign out_free  = !pulse_valid || pulse_ready;
	assign s1_go     = valid_s1 && (!(ok_s1 && is_fall) || out_free);
	assign cap_ready = !valid_s1 || s1_go;
	assign wr_en     = s1_go && ok_s1;
	assign wr_word   = is_fall ? {cur_rise, calc.width} : {ts_s1, cur_last};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ch_s1] <= wr_word;
		end
		if (cap_fire && in_range) begin
			rd_q <= mem[cap.channel[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cap_fire) begin
			ch_s1       <= cap.channel[AW-1:0];
			ts_s1       <= cap.timestamp[RW-1:0];
			byp_s1      <= wr_en && (ch_s1 == cap.channel[AW-1:0]);
			byp_word_s1 <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ok_s1    <= 1'b0;
			await_q  <= '0;
			vld_q    <= '0;
		end else begin
			if (cap_fire) begin
				valid_s1 <= 1'b1;
				ok_s1    <= in_range;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (wr_en) begin
				await_q[ch_s1] <= !is_fall;
				vld_q[ch_s1]   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_valid <= 1'b0;
		end else if (wr_en && is_fall) begin
			pulse_valid <= 1'b1;
		end else if (pulse_ready) begin
			pulse_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && is_fall) begin
			pulse.out_channel <= CH_BITS'(ch_s1);
			pulse.width       <= calc.width;
			pulse.rejected    <= calc.rejected;
		end
	end

endmodule
`default_nettype wire

// File: rtl/rcpwm_width_calc.sv
// Pulse width from rise and fall times, with clamping and glitch rejection.
`default_nettype none
module rcpwm_width_calc (
	input  wire logic [rcpwm_pkg::TS_BITS-1:0]     fall_time,
	input  wire logic [rcpwm_pkg::TS_BITS-1:0]     rise_time,
	input  wire logic [rcpwm_pkg::WIDTH_BITS-1:0]  last_width,
	input  wire logic [rcpwm_pkg::PERIOD_BITS-1:0] counter_period,
	input  wire logic [rcpwm_pkg::WIDTH_BITS-1:0]  max_jump,
	output rcpwm_pkg::calc_t                       result
);
	import rcpwm_pkg::*;

	logic                   wrap;
	logic signed [18:0]     raw;
	logic [WIDTH_BITS-1:0]  clamped;
	logic [WIDTH_BITS-1:0]  diff;

	always_comb begin
		wrap = fall_time < rise_time;
		raw  = $signed({3'b000, fall_time}) - $signed({3'b000, rise_time})
			+ (wrap ? $signed({2'b00, counter_period}) : 19'sd0);
		// A small period can leave a wrapped width below zero.
		if (raw[18]) begin
			clamped = '0;
		end else if (|raw[17:16]) begin
			clamped = WIDTH_MAX;
		end else begin
			clamped = raw[15:0];
		end
		diff = (clamped >= last_width) ? clamped - last_width : last_width - clamped;
		if (diff > max_jump) begin
			result.width    = last_width;
			result.rejected = 1'b1;
		end else begin
			result.width    = clamped;
			result.rejected = 1'b0;
		end
	end

endmodule
`default_nettype wire

// File: rtl/rcpwm_checker.sv
// Port-level checks of the RC PWM pulse-width decoder, bound to the top level.
`default_nettype none
module rcpwm_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cap_valid,
	input wire logic              cap_ready,
	input wire rcpwm_pkg::pulse_t pulse,
	input wire logic              pulse_valid,
	input wire logic              pulse_ready,
	input wire logic              cfg_valid,
	input wire logic              cfg_ready
);
	import rcpwm_pkg::*;

	// A stalled result keeps its value until its transfer.
	a_pulse_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_valid && !pulse_ready |=> pulse_valid && $stable(pulse))
		else $error("pulse changed or dropped while stalled");

	// With the result register empty the second stage can always drain.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!pulse_valid |-> cap_ready)
		else $error("capture input stalled with no pending result");

	// A fresh result comes from a capture transfer through the second stage.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pulse_valid) |-> $past(cap_valid && cap_ready, 2))
		else $error("result appeared without a matching capture transfer");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write was stalled");

endmodule

bind rc_pwm_pulse_width_decoder rcpwm_checker u_rcpwm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cap_valid   (cap_valid),
	.cap_ready   (cap_ready),
	.pulse       (pulse),
	.pulse_valid (pulse_valid),
	.pulse_ready (pulse_ready),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready)
);
`default_nettype wire
